FILE: rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants of the stick position calibrator
// Action codes, field widths, scaling constants and default parameters.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned CHANNEL_W = 3;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned CFG_W     = 8;

  localparam int unsigned HALF_SCALE   = 500;
  localparam int unsigned FULL_SCALE   = 1000;
  localparam int unsigned EDGE_DIVISOR = 20;
  localparam int unsigned COUNT_MAX    = 255;

  localparam int unsigned DEF_NUM_CHANNELS = 8;
  localparam int unsigned DEF_SAMPLE_BITS  = 12;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CONVERT     = 3'd0,
    ACT_EDGE_SAMPLE = 3'd1,
    ACT_EDGE_FINISH = 3'd2,
    ACT_MID_SAMPLE  = 3'd3,
    ACT_MID_FINISH  = 3'd4
  } action_e;

endpackage

FILE: rtl/spc_div.sv
// ----------------------------------------------------------------------------
// spc_div: radix-2 serial divider
// Restoring division, one quotient bit per cycle. The dividend bits sit in a
// shift register that takes the quotient bits in at the bottom; the caller
// preloads the partial remainder and the number of steps.
// ----------------------------------------------------------------------------
module spc_div import spc_pkg::*; #(
  parameter int unsigned DIV_W = DEF_SAMPLE_BITS,
  parameter int unsigned QUO_W = DEF_SAMPLE_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [$clog2(QUO_W+1)-1:0] steps_i,
  input  logic [DIV_W-1:0]           rem_i,
  input  logic [QUO_W-1:0]           num_i,
  input  logic [DIV_W-1:0]           den_i,
  output logic                       done_o,
  output logic [QUO_W-1:0]           quo_o
);

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic               busy_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DIV_W-1:0]   rem_q;
  logic [DIV_W-1:0]   den_q;
  logic [QUO_W-1:0]   num_q;
  logic [DIV_W:0]     shifted;
  logic [DIV_W+1:0]   trial;
  logic               fits;

  always_comb begin
    shifted = {rem_q, num_q[QUO_W-1]};
    trial   = {1'b0, shifted} - {2'b00, den_q};
    fits    = ~trial[DIV_W+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      num_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
      num_q <= {num_q[QUO_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

FILE: rtl/stick_position_calibrator.sv
// ----------------------------------------------------------------------------
// stick_position_calibrator: per-channel stick and knob conditioner
// Maps raw samples to 0..1000 around a calibrated centre, tracks end points
// and averages centre samples, one request at a time.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                   payload
//  in       input      in_valid_i / in_stall_o     action_i, channel_i, sample_i
//  out      output     out_valid_o / out_stall_i   position_o, new_extreme_o,
//                                                  count_full_o
//  cfg      input      cfg_valid_i / cfg_ready_o   cfg_data_i (reverse mask)
//
//  Acceptance to output register: a request passes the PREP state, then the DIV
//  state if it divides (a saturated convert does not), where the radix-2 divider
//  yields one quotient bit a cycle, then DONE, which loads the output register.
//  Reset is asynchronous and loads the limit, centre and sum defaults at once.
//  A result waits in the output register while out_stall_i is high; the next
//  request is taken meanwhile and held before its hand-over until it frees.
// ----------------------------------------------------------------------------
module stick_position_calibrator import spc_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int unsigned SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [ACTION_W-1:0]    action_i,
  input  logic [CHANNEL_W-1:0]   channel_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [POS_W-1:0]       position_o,
  output logic                   new_extreme_o,
  output logic                   count_full_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned QW     = (SB > POS_W) ? SB : POS_W;
  localparam int unsigned PROD_W = SB + $clog2(HALF_SCALE + 1);
  localparam int unsigned SUM_W  = SB + COUNT_W;
  localparam int unsigned CNT_W  = $clog2(QW + 1);
  localparam int unsigned CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [SB-1:0] CENTRE_RST = SB'(1) << (SB - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic [ACTION_W-1:0]    action_q;
  logic [CHANNEL_W-1:0]   channel_q;
  logic [SB-1:0]          sample_q;
  logic [CFG_W-1:0]       rev_mask_q;

  logic [SB-1:0]          low_q    [NUM_CHANNELS];
  logic [SB-1:0]          high_q   [NUM_CHANNELS];
  logic [SB-1:0]          centre_q [NUM_CHANNELS];
  logic [SUM_W-1:0]       sum_q    [NUM_CHANNELS];
  logic [COUNT_W-1:0]     count_q  [NUM_CHANNELS];

  logic [POS_W-1:0]       res_pos_q;
  logic                   res_ext_q;
  logic                   res_full_q;
  logic                   out_valid_q;
  logic [POS_W-1:0]       out_pos_q;
  logic                   out_ext_q;
  logic                   out_full_q;

  logic [CH_W-1:0]        ch_idx;
  logic                   ch_ok;
  logic                   rev;
  logic [SB-1:0]          mid;
  logic [SB-1:0]          lo;
  logic [SB-1:0]          hi;
  logic [SUM_W-1:0]       sum;
  logic [COUNT_W-1:0]     cnt;
  logic                   above;
  logic [SB-1:0]          diff;
  logic [SB:0]            span_s;
  logic [SB-1:0]          span;
  logic [PROD_W-1:0]      prod;
  logic [SB-2:0]          prod_hi;
  logic                   conv_over;
  logic                   edge_pos;
  logic [POS_W-1:0]       quo_off;
  logic                   out_load;

  logic                   div_start;
  logic [CNT_W-1:0]       div_steps;
  logic [SB-1:0]          div_rem;
  logic [QW-1:0]          div_num;
  logic [SB-1:0]          div_den;
  logic                   div_done;
  logic [QW-1:0]          div_quo;

  function automatic logic [POS_W-1:0] map_pos(input logic up, input logic mirror,
                                               input logic [POS_W-1:0] off);
    logic [POS_W-1:0] fwd;
    fwd = up ? POS_W'(HALF_SCALE) + off : POS_W'(HALF_SCALE) - off;
    return mirror ? POS_W'(FULL_SCALE) - fwd : fwd;
  endfunction

  always_comb begin
    ch_idx    = CH_W'(channel_q);
    ch_ok     = 32'(channel_q) < NUM_CHANNELS;
    rev       = rev_mask_q[channel_q];
    mid       = centre_q[ch_idx];
    lo        = low_q[ch_idx];
    hi        = high_q[ch_idx];
    sum       = sum_q[ch_idx];
    cnt       = count_q[ch_idx];
    above     = sample_q >= mid;
    diff      = above ? sample_q - mid : mid - sample_q;
    span_s    = above ? {1'b0, hi} - {1'b0, mid} : {1'b0, mid} - {1'b0, lo};
    span      = (span_s[SB] || span_s == '0) ? SB'(1) : span_s[SB-1:0];
    prod      = PROD_W'(diff) * PROD_W'(HALF_SCALE);
    prod_hi   = prod[PROD_W-1:POS_W];
    conv_over = SB'(prod_hi) >= span;
    edge_pos  = hi > lo;
    quo_off   = (div_quo > QW'(HALF_SCALE)) ? POS_W'(HALF_SCALE) : div_quo[POS_W-1:0];
    out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    div_start = 1'b0;
    div_steps = CNT_W'(SB);
    div_rem   = '0;
    div_num   = '0;
    div_den   = SB'(1);
    case (action_q)
      ACT_CONVERT: begin
        div_start = (state_q == ST_PREP) && ch_ok && !conv_over;
        div_steps = CNT_W'(POS_W);
        div_rem   = SB'(prod_hi);
        div_num   = QW'(prod[POS_W-1:0]) << (QW - POS_W);
        div_den   = span;
      end
      ACT_EDGE_FINISH: begin
        div_start = (state_q == ST_PREP) && ch_ok && edge_pos;
        div_num   = QW'(hi - lo) << (QW - SB);
        div_den   = SB'(EDGE_DIVISOR);
      end
      ACT_MID_FINISH: begin
        div_start = (state_q == ST_PREP) && ch_ok && (cnt != '0);
        div_rem   = SB'(sum[SUM_W-1:SB]);
        div_num   = QW'(sum[SB-1:0]) << (QW - SB);
        div_den   = SB'(cnt);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  spc_div #(
    .DIV_W (SB),
    .QUO_W (QW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .steps_i (div_steps),
    .rem_i   (div_rem),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      rev_mask_q  <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        low_q[i]    <= '1;
        high_q[i]   <= '0;
        centre_q[i] <= CENTRE_RST;
        sum_q[i]    <= '0;
        count_q[i]  <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        rev_mask_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            action_q  <= action_i;
            channel_q <= channel_i;
            sample_q  <= sample_i;
            state_q   <= ST_PREP;
          end
        end
        ST_PREP: begin
          res_pos_q  <= (ch_ok && (action_q == ACT_CONVERT) && conv_over) ?
                        map_pos(above, rev, POS_W'(HALF_SCALE)) : '0;
          res_ext_q  <= ch_ok && (action_q == ACT_EDGE_SAMPLE) &&
                        ((sample_q > hi) || (sample_q < lo));
          res_full_q <= ch_ok && (action_q == ACT_MID_SAMPLE) &&
                        (cnt >= COUNT_W'(COUNT_MAX));
          state_q    <= div_start ? ST_DIV : ST_DONE;
          if (ch_ok) begin
            case (action_q)
              ACT_EDGE_SAMPLE: begin
                if (sample_q > hi) begin
                  high_q[ch_idx] <= sample_q;
                end
                if (sample_q < lo) begin
                  low_q[ch_idx] <= sample_q;
                end
              end
              ACT_MID_SAMPLE: begin
                if (cnt < COUNT_W'(COUNT_MAX)) begin
                  sum_q[ch_idx]   <= sum + SUM_W'(sample_q);
                  count_q[ch_idx] <= cnt + COUNT_W'(1);
                end
              end
              ACT_MID_FINISH: begin
                if (cnt == '0) begin
                  centre_q[ch_idx] <= sum[SB-1:0];
                  sum_q[ch_idx]    <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_DONE;
            case (action_q)
              ACT_CONVERT: begin
                res_pos_q <= map_pos(above, rev, quo_off);
              end
              ACT_EDGE_FINISH: begin
                high_q[ch_idx] <= hi - div_quo[SB-1:0];
                low_q[ch_idx]  <= lo + div_quo[SB-1:0];
              end
              ACT_MID_FINISH: begin
                centre_q[ch_idx] <= div_quo[SB-1:0];
                sum_q[ch_idx]    <= '0;
                count_q[ch_idx]  <= '0;
              end
              default: begin
                res_pos_q <= '0;
              end
            endcase
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_pos_q  <= res_pos_q;
            out_ext_q  <= res_ext_q;
            out_full_q <= res_full_q;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign position_o    = out_pos_q;
  assign new_extreme_o = out_ext_q;
  assign count_full_o  = out_full_q;
  assign cfg_ready_o   = 1'b1;

endmodule
